// ===== sv/assert_macros.svh =====
// Assertion macros used by the checker file of the transform core.
// Depends on nothing; each macro expands to one labeled concurrent assertion.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge outside reset.
`define ASSERT_RUN(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");

// Check a property on every rising edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("assertion failed");

`endif

// ===== sv/wht_pkg.sv =====
// Types and constants of the 128-point Walsh-Hadamard transform core.
// Depends on nothing; every module of the core uses it by scoped names.
`timescale 1ns / 1ps

package wht_pkg;

  localparam int POINTS    = 128;
  localparam int LANES     = 4;
  localparam int LANE_BITS = $clog2(LANES);
  localparam int ROWS      = POINTS / LANES;
  localparam int ROW_W     = $clog2(ROWS);
  localparam int SLOTS     = ROWS / 2;
  localparam int SLOT_W    = $clog2(SLOTS);
  localparam int STAGES    = $clog2(POINTS);
  localparam int STAGE_W   = $clog2(STAGES + 1);
  localparam int IN_W      = 32;
  localparam int COEF_W    = 32;
  localparam int ACC_W     = 39;

  // Scale 1/sqrt(128) in Q24, rounded
  localparam int SCALE_W    = 22;
  localparam int SCALE_Q24  = 1482910;
  localparam int SCALE_SH   = 24;
  localparam int PROD_W     = ACC_W + SCALE_W;

  typedef logic signed [ACC_W-1:0]  acc_t;
  typedef acc_t [LANES-1:0]         row_t;
  typedef logic signed [COEF_W-1:0] coef_t;
  typedef coef_t [LANES-1:0]        coef_row_t;

  typedef struct packed {
    logic signed [IN_W-1:0] sample_a;
    logic signed [IN_W-1:0] sample_b;
    logic signed [IN_W-1:0] sample_c;
    logic signed [IN_W-1:0] sample_d;
  } in_item_t;

  typedef struct packed {
    logic signed [COEF_W-1:0] coef_a;
    logic signed [COEF_W-1:0] coef_b;
    logic signed [COEF_W-1:0] coef_c;
    logic signed [COEF_W-1:0] coef_d;
    logic                     last_of_vector;
    logic                     clipped;
  } out_item_t;

  // Scaled row with its saturation status
  typedef struct packed {
    coef_row_t coef;
    logic      clip;
  } scale_res_t;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_X_RD,
    ST_X_WA,
    ST_X_WB,
    ST_O_RD,
    ST_O_MUL,
    ST_O_SAT
  } state_t;

endpackage

// ===== sv/wht_ram.sv =====
// Vector store: 32 rows of four 39-bit words, one write port, two read ports.
// Depends on wht_pkg for the row type and depth; read data is registered.
`timescale 1ns / 1ps

module wht_ram (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [wht_pkg::ROW_W-1:0] wr_addr,
  input  wht_pkg::row_t            wr_data,
  input  logic [wht_pkg::ROW_W-1:0] rd_addr_a,
  input  logic [wht_pkg::ROW_W-1:0] rd_addr_b,
  output wht_pkg::row_t            rd_data_a,
  output wht_pkg::row_t            rd_data_b
);

  wht_pkg::row_t mem [wht_pkg::ROWS];

  // Write one row
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read two rows, registered
  always_ff @(posedge clk) begin
    rd_data_a <= mem[rd_addr_a];
    rd_data_b <= mem[rd_addr_b];
  end

endmodule

// ===== sv/wht_bfly.sv =====
// Butterfly unit: two rows in, two rows out, for one transform stage.
// Depends on wht_pkg; low stages pair lanes inside a row, high stages pair rows.
`timescale 1ns / 1ps

module wht_bfly (
  input  logic [wht_pkg::STAGE_W-1:0] stage,
  input  wht_pkg::row_t               row_a,
  input  wht_pkg::row_t               row_b,
  output wht_pkg::row_t               res_a,
  output wht_pkg::row_t               res_b
);

  // Sum and difference of lane pairs at stride 2^stage inside one row
  function automatic wht_pkg::row_t intra(input wht_pkg::row_t x,
                                          input logic [wht_pkg::STAGE_W-1:0] st);
    wht_pkg::row_t r;
    logic [wht_pkg::LANE_BITS-1:0] lane;
    logic [wht_pkg::LANE_BITS-1:0] mate;
    logic [wht_pkg::LANE_BITS-1:0] hbit;
    r = x;
    hbit = wht_pkg::LANE_BITS'(1) << st;
    for (int l = 0; l < wht_pkg::LANES; l++) begin
      lane = wht_pkg::LANE_BITS'(l);
      mate = lane ^ hbit;
      if ((lane & hbit) == '0) begin
        r[lane] = x[lane] + x[mate];
      end else begin
        r[lane] = x[mate] - x[lane];
      end
    end
    return r;
  endfunction

  // Pick in-row or cross-row pairing by stage
  always_comb begin
    if (stage < wht_pkg::STAGE_W'(wht_pkg::LANE_BITS)) begin
      res_a = intra(row_a, stage);
      res_b = intra(row_b, stage);
    end else begin
      for (int l = 0; l < wht_pkg::LANES; l++) begin
        res_a[l] = row_a[l] + row_b[l];
        res_b[l] = row_a[l] - row_b[l];
      end
    end
  end

endmodule

// ===== sv/wht_scale.sv =====
// Output scaler: multiply a row by 1/sqrt(128) in Q24, round, saturate.
// Depends on wht_pkg; products are registered, rounding and clipping follow.
`timescale 1ns / 1ps

module wht_scale (
  input  logic                clk,
  input  logic                load,
  input  wht_pkg::row_t       data,
  output wht_pkg::scale_res_t res
);

  localparam int R_W = wht_pkg::PROD_W - wht_pkg::SCALE_SH;
  localparam logic signed [wht_pkg::PROD_W-1:0] SCALE =
    wht_pkg::PROD_W'(wht_pkg::SCALE_Q24);
  localparam logic signed [wht_pkg::PROD_W-1:0] BIAS =
    wht_pkg::PROD_W'(1) <<< (wht_pkg::SCALE_SH - 1);

  logic signed [wht_pkg::PROD_W-1:0] prod [wht_pkg::LANES];

  // Register one product per lane
  always_ff @(posedge clk) begin
    if (load) begin
      for (int l = 0; l < wht_pkg::LANES; l++) begin
        prod[l] <= wht_pkg::PROD_W'(data[l]) * SCALE;
      end
    end
  end

  // Round to nearest, ties up, then clip to 32 bits
  always_comb begin
    logic signed [wht_pkg::PROD_W-1:0] biased;
    logic signed [R_W-1:0]             r;
    res.clip = 1'b0;
    for (int l = 0; l < wht_pkg::LANES; l++) begin
      biased = prod[l] + BIAS;
      r = biased[wht_pkg::PROD_W-1:wht_pkg::SCALE_SH];
      if (r[R_W-1:wht_pkg::COEF_W-1] == '0 || r[R_W-1:wht_pkg::COEF_W-1] == '1) begin
        res.coef[l] = r[wht_pkg::COEF_W-1:0];
      end else begin
        res.clip = 1'b1;
        res.coef[l] = r[R_W-1] ? {1'b1, {(wht_pkg::COEF_W-1){1'b0}}}
                               : {1'b0, {(wht_pkg::COEF_W-1){1'b1}}};
      end
    end
  end

endmodule

// ===== sv/walsh_hadamard_128_transform_core.sv =====
// Flow: a 32-item vector is loaded one row per accepted item, then run through 7 stages
// (one write port stores a butterfly row pair in the write states ST_X_WA and ST_X_WB),
// then each result takes the steps row read, multiply, round and clip, the last waiting
// while a held result is not taken; no new vector is taken until its last result is registered.
// Reset: synchronous, active high; clears the sequencer, load count and output valid.
`timescale 1ns / 1ps

module walsh_hadamard_128_transform_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  wht_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_ready,
  output wht_pkg::out_item_t out_item
);

  wht_pkg::state_t state;
  wht_pkg::state_t state_next;

  logic [wht_pkg::ROW_W-1:0]   load_count;
  logic [wht_pkg::STAGE_W-1:0] stage;
  logic [wht_pkg::SLOT_W-1:0]  slot;
  logic [wht_pkg::ROW_W-1:0]   out_k;
  logic [wht_pkg::ROW_W-1:0]   wb_row;
  wht_pkg::row_t               hold_b;

  logic                        wr_en;
  logic [wht_pkg::ROW_W-1:0]   wr_addr;
  wht_pkg::row_t               wr_data;
  logic [wht_pkg::ROW_W-1:0]   rd_addr_a;
  logic [wht_pkg::ROW_W-1:0]   rd_addr_b;
  wht_pkg::row_t               rd_data_a;
  wht_pkg::row_t               rd_data_b;
  wht_pkg::row_t               res_a;
  wht_pkg::row_t               res_b;
  wht_pkg::row_t               in_row;
  wht_pkg::scale_res_t         sc_res;
  logic                        sc_load;
  logic                        out_load;

  logic [wht_pkg::ROW_W-1:0]   ra;
  logic [wht_pkg::ROW_W-1:0]   rb;
  logic [wht_pkg::STAGE_W-1:0] pos;
  logic [wht_pkg::ROW_W-1:0]   slot_ext;
  logic [wht_pkg::ROW_W-1:0]   pbit;

  // Sign-extend the incoming samples into one row
  assign in_row[0] = wht_pkg::ACC_W'(in_item.sample_a);
  assign in_row[1] = wht_pkg::ACC_W'(in_item.sample_b);
  assign in_row[2] = wht_pkg::ACC_W'(in_item.sample_c);
  assign in_row[3] = wht_pkg::ACC_W'(in_item.sample_d);

  // Row pair of this slot: insert a 0 or 1 bit at the row stride position
  always_comb begin
    pos = (stage < wht_pkg::STAGE_W'(wht_pkg::LANE_BITS)) ? '0
        : stage - wht_pkg::STAGE_W'(wht_pkg::LANE_BITS);
    slot_ext = wht_pkg::ROW_W'(slot);
    pbit = wht_pkg::ROW_W'(1) << pos;
    ra = ((slot_ext >> pos) << (pos + wht_pkg::STAGE_W'(1))) | (slot_ext & (pbit - 1'b1));
    rb = ra | pbit;
  end

  wht_ram u_ram (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_addr_a (rd_addr_a),
    .rd_addr_b (rd_addr_b),
    .rd_data_a (rd_data_a),
    .rd_data_b (rd_data_b)
  );

  wht_bfly u_bfly (
    .stage (stage),
    .row_a (rd_data_a),
    .row_b (rd_data_b),
    .res_a (res_a),
    .res_b (res_b)
  );

  wht_scale u_scale (
    .clk  (clk),
    .load (sc_load),
    .data (rd_data_a),
    .res  (sc_res)
  );

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= wht_pkg::ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

  // Next state, memory port control and handshakes
  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    wr_en      = 1'b0;
    wr_addr    = ra;
    wr_data    = res_a;
    rd_addr_a  = ra;
    rd_addr_b  = rb;
    sc_load    = 1'b0;
    out_load   = 1'b0;
    unique case (state)
      wht_pkg::ST_LOAD: begin
        in_ready = 1'b1;
        if (in_valid) begin
          wr_en   = 1'b1;
          wr_addr = load_count;
          wr_data = in_row;
          if (load_count == wht_pkg::ROW_W'(wht_pkg::ROWS - 1)) begin
            state_next = wht_pkg::ST_X_RD;
          end
        end
      end
      wht_pkg::ST_X_RD: begin
        state_next = wht_pkg::ST_X_WA;
      end
      wht_pkg::ST_X_WA: begin
        wr_en      = 1'b1;
        state_next = wht_pkg::ST_X_WB;
      end
      wht_pkg::ST_X_WB: begin
        // Store the held second row; the next slot's read goes out meanwhile
        wr_en   = 1'b1;
        wr_addr = wb_row;
        wr_data = hold_b;
        if (slot != '0) begin
          state_next = wht_pkg::ST_X_WA;
        end else if (stage == wht_pkg::STAGE_W'(wht_pkg::STAGES)) begin
          state_next = wht_pkg::ST_O_RD;
        end else begin
          state_next = wht_pkg::ST_X_RD;
        end
      end
      wht_pkg::ST_O_RD: begin
        rd_addr_a  = out_k;
        state_next = wht_pkg::ST_O_MUL;
      end
      wht_pkg::ST_O_MUL: begin
        rd_addr_a  = out_k;
        sc_load    = 1'b1;
        state_next = wht_pkg::ST_O_SAT;
      end
      wht_pkg::ST_O_SAT: begin
        rd_addr_a = out_k;
        if (!out_valid || out_ready) begin
          out_load   = 1'b1;
          state_next = (out_k == wht_pkg::ROW_W'(wht_pkg::ROWS - 1)) ? wht_pkg::ST_LOAD
                                                                     : wht_pkg::ST_O_RD;
        end
      end
      default: begin
        state_next = wht_pkg::ST_LOAD;
      end
    endcase
  end

  // Advance load count, stage and slot counters, output index and valid
  always_ff @(posedge clk) begin
    if (rst) begin
      load_count <= '0;
      stage      <= '0;
      slot       <= '0;
      out_k      <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        load_count <= load_count + 1'b1;
      end
      if (state == wht_pkg::ST_LOAD) begin
        stage <= '0;
        slot  <= '0;
      end else if (state == wht_pkg::ST_X_WA) begin
        slot <= slot + 1'b1;
        if (slot == wht_pkg::SLOT_W'(wht_pkg::SLOTS - 1)) begin
          stage <= stage + 1'b1;
        end
      end
      if (out_load) begin
        out_valid <= 1'b1;
        out_k     <= out_k + 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Hold the second butterfly row and the result payload
  always_ff @(posedge clk) begin
    if (state == wht_pkg::ST_X_WA) begin
      hold_b <= res_b;
      wb_row <= rb;
    end
    if (out_load) begin
      out_item.coef_a         <= sc_res.coef[0];
      out_item.coef_b         <= sc_res.coef[1];
      out_item.coef_c         <= sc_res.coef[2];
      out_item.coef_d         <= sc_res.coef[3];
      out_item.last_of_vector <= (out_k == wht_pkg::ROW_W'(wht_pkg::ROWS - 1));
      out_item.clipped        <= sc_res.clip;
    end
  end

endmodule

// ===== sv/wht_checker.sv =====
// Port-level checker for the transform core, bound to its top level.
// Depends on wht_pkg for the item types and on assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module wht_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input wht_pkg::out_item_t out_item
);

  logic rail_hit;

  // Flag a rail value on any lane of the result
  assign rail_hit = out_item.coef_a == 32'h7FFF_FFFF || out_item.coef_a == 32'h8000_0000 ||
                    out_item.coef_b == 32'h7FFF_FFFF || out_item.coef_b == 32'h8000_0000 ||
                    out_item.coef_c == 32'h7FFF_FFFF || out_item.coef_c == 32'h8000_0000 ||
                    out_item.coef_d == 32'h7FFF_FFFF || out_item.coef_d == 32'h8000_0000;

  // A stalled result holds
  `ASSERT_RUN(a_out_hold, clk, rst, out_valid && !out_ready |=> out_valid && $stable(out_item))

  // No loading while a vector's results are still being produced
  `ASSERT_RUN(a_no_load_mid_vector, clk, rst, out_valid && !out_item.last_of_vector |-> !in_ready)

  // A clipped item carries at least one rail value
  `ASSERT_RUN(a_clip_rail, clk, rst, out_valid && out_item.clipped |-> rail_hit)

  // Reset leaves the block loading with no result pending
  `ASSERT_ALWAYS(a_reset_state, clk, rst |=> in_ready && !out_valid)

endmodule

bind walsh_hadamard_128_transform_core wht_checker u_wht_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_item  (out_item)
);
